@@ hdl/qspc_pkg.sv @@
// shared types, codes and constants for the quadrature servo position controller
// no dependencies; used by every module of the block by scoped names

package qspc_pkg;

    // width of the internal position counter (16 to 64)
    localparam int POSITION_BITS = 32;

    // port widths fixed by the item fields
    localparam int OUT_POS_BITS = 32;
    localparam int TARGET_BITS  = 32;
    localparam int SCALE_BITS   = 10;
    localparam int DUTY_BITS    = 17;
    localparam int DIR_BITS     = 2;
    localparam int SPEED_BITS   = 7;

    // signed difference of target and position never overflows at this width
    localparam int WIDE_BITS = (POSITION_BITS > TARGET_BITS) ? POSITION_BITS : TARGET_BITS;
    localparam int DIFF_BITS = WIDE_BITS + 1;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(50);

    // control law constants
    localparam logic [SPEED_BITS-1:0] SPEED_MAX  = SPEED_BITS'(100);
    localparam logic [SPEED_BITS-1:0] SPEED_BIAS = SPEED_BITS'(25);
    localparam logic [DIFF_BITS-1:0]  DIST_LIMIT = DIFF_BITS'(200);

    // item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // drive direction codes
    localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_REV  = 2'd2;

    typedef struct packed {
        logic [DIR_BITS-1:0]  dir;
        logic [DUTY_BITS-1:0] duty;
    } drive_cmd_t;

endpackage

@@ hdl/qspc_decoder.sv @@
// quadrature step decoder: one gray-code step of the a/b pair moves the count by one
// depends on qspc_pkg

module qspc_decoder
(
    input  logic [1:0]                        prev_chan,
    input  logic [1:0]                        now_chan,
    input  logic [qspc_pkg::POSITION_BITS-1:0] position,
    output logic [qspc_pkg::POSITION_BITS-1:0] position_next
);

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    // forward sequence 0 -> 1 -> 3 -> 2 -> 0, a in bit 0
    function automatic logic [1:0] step_of(input logic [3:0] code);
        logic [1:0] step;
        begin
            case (code)
                4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: step = STEP_UP;
                4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: step = STEP_DOWN;
                default:                                step = STEP_NONE;
            endcase
            return step;
        end
    endfunction

    logic [1:0] step;

    assign step = step_of({prev_chan, now_chan});

    always_comb
    begin
        case (step)
            STEP_UP:   position_next = position + qspc_pkg::POSITION_BITS'(1);
            STEP_DOWN: position_next = position - qspc_pkg::POSITION_BITS'(1);
            default:   position_next = position;
        endcase
    end

endmodule

@@ hdl/qspc_drive.sv @@
// proportional drive law: distance to target gives a biased, clamped speed and a duty
// depends on qspc_pkg

module qspc_drive
(
    input  logic [qspc_pkg::TARGET_BITS-1:0]   target,
    input  logic [qspc_pkg::POSITION_BITS-1:0] position,
    input  logic [qspc_pkg::DIR_BITS-1:0]      last_dir,
    input  qspc_pkg::drive_cmd_t               cmd,
    input  logic [qspc_pkg::SCALE_BITS-1:0]    scale,
    output logic [qspc_pkg::DIR_BITS-1:0]      last_dir_next,
    output qspc_pkg::drive_cmd_t               cmd_next
);

    localparam int DW = qspc_pkg::DIFF_BITS;
    localparam int SW = qspc_pkg::SPEED_BITS;

    logic signed [DW-1:0] target_ext;
    logic signed [DW-1:0] position_ext;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        dist_mag;
    logic                 ahead;
    logic [SW-1:0]        base_speed;
    logic [SW-1:0]        biased;
    logic [SW-1:0]        speed;
    logic [qspc_pkg::DIR_BITS-1:0] dir;

    assign target_ext   = DW'(signed'(target));
    assign position_ext = DW'(signed'(position));
    assign diff         = target_ext - position_ext;
    assign ahead        = !diff[DW-1];
    assign dist_mag     = ahead ? diff : -diff;
    assign dir          = ahead ? qspc_pkg::DIR_FWD : qspc_pkg::DIR_REV;

    // at or below the distance limit, half the distance is at most 100
    assign base_speed = (dist_mag > qspc_pkg::DIST_LIMIT) ? qspc_pkg::SPEED_MAX
                                                          : SW'(dist_mag >> 1);
    assign biased     = base_speed + qspc_pkg::SPEED_BIAS;
    assign speed      = (biased > qspc_pkg::SPEED_MAX) ? qspc_pkg::SPEED_MAX : biased;

    always_comb
    begin
        last_dir_next = last_dir;
        cmd_next      = cmd;
        if (diff == '0)
        begin
            // on target: stop, keeping the last direction if there is one
            if (last_dir == qspc_pkg::DIR_FWD || last_dir == qspc_pkg::DIR_REV)
            begin
                cmd_next.dir  = last_dir;
                cmd_next.duty = '0;
            end
        end
        else
        begin
            last_dir_next = dir;
            cmd_next.dir  = dir;
            cmd_next.duty = qspc_pkg::DUTY_BITS'(speed * scale);
        end
    end

endmodule

@@ hdl/quadrature_servo_position_controller.sv @@
// Quadrature servo position controller.
// Input channel (in_valid/in_ready) carries one beat per item: mode 0 is an
// encoder sample (chan_a, chan_b), mode 1 a control tick (target_position).
// Output channel (out_valid/out_ready) returns one beat per item with the
// position count and the drive command as they stand after that item.
// The duty scale register is written through cfg_we/cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
// An accepted beat waits in the input register and is decoded into the
// result register once that can advance. Throughput: one item per cycle
// while results are taken; the input and result registers each hold one
// beat; each update is combinational add, compare and 7 by 10 bit multiply.
// When the receiver stalls, the result holds and the input register fills;
// in_ready then drops until the result is taken.
// Reset clears position, channel history, direction and command to zero
// and loads a duty scale of 50.
// Depends on qspc_pkg, qspc_decoder and qspc_drive.

module quadrature_servo_position_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic                                chan_a,
    input  logic                                chan_b,
    input  logic signed [qspc_pkg::TARGET_BITS-1:0]  target_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qspc_pkg::OUT_POS_BITS-1:0] current_position,
    output logic [qspc_pkg::DIR_BITS-1:0]       drive_direction,
    output logic [qspc_pkg::DUTY_BITS-1:0]      drive_duty,
    input  logic                                cfg_we,
    input  logic [qspc_pkg::SCALE_BITS-1:0]     cfg_wdata
);

    localparam int PW = qspc_pkg::POSITION_BITS;

    // input stage
    logic                             in_valid_reg;
    logic                             mode_reg;
    logic [1:0]                       chan_reg;
    logic [qspc_pkg::TARGET_BITS-1:0] target_reg;

    // state, which also serves as the result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [PW-1:0]                   position_reg;
    logic [PW-1:0]                   position_next;
    logic [1:0]                      prev_chan_reg;
    logic [1:0]                      prev_chan_next;
    logic [qspc_pkg::DIR_BITS-1:0]   last_dir_reg;
    logic [qspc_pkg::DIR_BITS-1:0]   last_dir_next;
    qspc_pkg::drive_cmd_t            cmd_reg;
    qspc_pkg::drive_cmd_t            cmd_next;
    logic [qspc_pkg::SCALE_BITS-1:0] scale_reg;

    logic                            advance;
    logic                            fire;
    logic [PW-1:0]                   dec_position;
    logic [qspc_pkg::DIR_BITS-1:0]   drv_last_dir;
    qspc_pkg::drive_cmd_t            drv_cmd;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    qspc_decoder u_decoder
    (
        .prev_chan     (prev_chan_reg),
        .now_chan      (chan_reg),
        .position      (position_reg),
        .position_next (dec_position)
    );

    qspc_drive u_drive
    (
        .target        (target_reg),
        .position      (position_reg),
        .last_dir      (last_dir_reg),
        .cmd           (cmd_reg),
        .scale         (scale_reg),
        .last_dir_next (drv_last_dir),
        .cmd_next      (drv_cmd)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        position_next  = position_reg;
        prev_chan_next = prev_chan_reg;
        last_dir_next  = last_dir_reg;
        cmd_next       = cmd_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
        if (fire)
        begin
            if (mode_reg == qspc_pkg::MODE_SAMPLE)
            begin
                position_next  = dec_position;
                prev_chan_next = chan_reg;
            end
            else
            begin
                last_dir_next = drv_last_dir;
                cmd_next      = drv_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            prev_chan_reg <= '0;
            last_dir_reg  <= qspc_pkg::DIR_NONE;
            cmd_reg       <= '0;
            scale_reg     <= qspc_pkg::SCALE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            position_reg  <= position_next;
            prev_chan_reg <= prev_chan_next;
            last_dir_reg  <= last_dir_next;
            cmd_reg       <= cmd_next;
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
        end
    end

    // input payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg   <= mode;
            chan_reg   <= {chan_b, chan_a};
            target_reg <= target_position;
        end
    end

    assign out_valid        = out_valid_reg;
    assign current_position = qspc_pkg::OUT_POS_BITS'(position_reg);
    assign drive_direction  = cmd_reg.dir;
    assign drive_duty       = cmd_reg.duty;

`ifndef NO_ASSERTIONS
    // a stalled input beat is never dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat lost while stalled");

    // an encoder sample moves the count by at most one
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_reg == qspc_pkg::MODE_SAMPLE |=>
            position_reg == $past(position_reg) ||
            position_reg == $past(position_reg) + PW'(1) ||
            position_reg == $past(position_reg) - PW'(1))
        else $error("position moved by more than one count");

    // a control tick never touches the count
    a_tick_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_reg == qspc_pkg::MODE_TICK |=> $stable(position_reg))
        else $error("control tick changed the position");

    // no duty without a direction
    a_duty_dir: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg.dir == qspc_pkg::DIR_NONE |-> cmd_reg.duty == '0)
        else $error("duty set with no direction");

    // command and last direction agree once a direction is set
    a_dir_match: assert property (@(posedge clk) disable iff (!rst_n)
        last_dir_reg != qspc_pkg::DIR_NONE |-> cmd_reg.dir == last_dir_reg)
        else $error("drive direction differs from last direction");
`endif

endmodule

@@ sim/tb_quadrature_servo_position_controller.sv @@
// testbench for quadrature_servo_position_controller: encoder samples and control ticks
// are checked beat by beat against an in-bench model of decode and drive law
// depends on qspc_pkg and the block's top level only
`timescale 1ns / 100ps

module tb_quadrature_servo_position_controller;

    import qspc_pkg::*;

    typedef struct {
        logic signed [OUT_POS_BITS-1:0] pos;
        logic [DIR_BITS-1:0]            dir;
        logic [DUTY_BITS-1:0]           duty;
    } servo_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            mode;
    logic                            chan_a;
    logic                            chan_b;
    logic signed [TARGET_BITS-1:0]   target_position;
    logic                            out_valid;
    logic                            out_ready;
    logic signed [OUT_POS_BITS-1:0]  current_position;
    logic [DIR_BITS-1:0]             drive_direction;
    logic [DUTY_BITS-1:0]            drive_duty;
    logic                            cfg_we;
    logic [SCALE_BITS-1:0]           cfg_wdata;

    // model of the block state
    logic signed [POSITION_BITS-1:0] enc_count;
    logic [1:0]                      enc_prev_code;
    logic [DIR_BITS-1:0]             last_drive_dir;
    logic [DIR_BITS-1:0]             drive_dir_q;
    logic [DUTY_BITS-1:0]            drive_duty_q;
    logic [SCALE_BITS-1:0]           duty_scale_q;

    servo_result_t expected_beats[$];
    int            mismatch_count;
    int            send_calm;
    int            sink_calm;

    quadrature_servo_position_controller u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .chan_a           (chan_a),
        .chan_b           (chan_b),
        .target_position  (target_position),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .current_position (current_position),
        .drive_direction  (drive_direction),
        .drive_duty       (drive_duty),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // next code of the forward gray cycle 0 -> 1 -> 3 -> 2 -> 0
    function automatic logic [1:0] next_fwd(input logic [1:0] code);
        case (code)
            2'd0:    return 2'd1;
            2'd1:    return 2'd3;
            2'd3:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    // cycles to hold off before the next beat, with runs of no idling
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic servo_result_t advance_servo(input logic item_mode, input logic a,
                                                    input logic b,
                                                    input logic signed [TARGET_BITS-1:0] target);
        logic [1:0]                  code;
        logic signed [DIFF_BITS-1:0] offset;
        logic [DIFF_BITS-1:0]        dist_mag;
        int unsigned                 speed;
        servo_result_t               res;
        code = {b, a};
        if (item_mode == MODE_SAMPLE)
        begin
            if (code == next_fwd(enc_prev_code))
                enc_count = enc_count + 1'b1;
            else if (enc_prev_code == next_fwd(code))
                enc_count = enc_count - 1'b1;
            enc_prev_code = code;
        end
        else
        begin
            offset = DIFF_BITS'(target) - DIFF_BITS'(enc_count);
            if (offset == 0)
            begin
                // on target: stop in the last direction, nothing if none yet
                if (last_drive_dir != DIR_NONE)
                begin
                    drive_dir_q  = last_drive_dir;
                    drive_duty_q = '0;
                end
            end
            else
            begin
                last_drive_dir = (offset > 0) ? DIR_FWD : DIR_REV;
                dist_mag = (offset > 0) ? offset : -offset;
                speed    = (dist_mag > DIST_LIMIT) ? SPEED_MAX : dist_mag / 2;
                speed    = speed + SPEED_BIAS;
                if (speed > SPEED_MAX)
                    speed = SPEED_MAX;
                drive_dir_q  = last_drive_dir;
                drive_duty_q = DUTY_BITS'(speed * duty_scale_q);
            end
        end
        res.pos  = OUT_POS_BITS'(enc_count);
        res.dir  = drive_dir_q;
        res.duty = drive_duty_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t: %s differs: got %0d, expected %0d", $time, what, got, want);
    endtask

    // starts and ends at a falling edge; valid stays high across back-to-back beats
    task automatic send_item(input logic item_mode, input logic a, input logic b,
                             input logic signed [TARGET_BITS-1:0] target);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= item_mode;
        chan_a          <= a;
        chan_b          <= b;
        target_position <= target;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_beats.push_back(advance_servo(item_mode, a, b, target));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_BITS-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        duty_scale_q = value;
    endtask

    task automatic test_reset_command();
        // target equal to position before any direction: command stays at reset
        send_item(MODE_TICK, 1'b1, 1'b1, '0);
    endtask

    task automatic test_encoder_steps();
        // unchanged, reverse past zero, double steps, forward run, reverse run
        logic [1:0] codes[12] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2,
                                  2'd0, 2'd1, 2'd3, 2'd1, 2'd0, 2'd3};
        foreach (codes[i])
            send_item(MODE_SAMPLE, codes[i][0], codes[i][1], $urandom);
    endtask

    task automatic test_control_law();
        // around the halving and bias clamp, the distance limit, and on target
        int offsets[10] = '{1, 2, 149, 150, 151, 201, -1, -200, -201, 0};
        foreach (offsets[i])
            send_item(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      TARGET_BITS'(enc_count) + TARGET_BITS'(offsets[i]));
        send_item(MODE_TICK, 1'b0, 1'b1, 32'sh7FFF_FFFF);
        send_item(MODE_TICK, 1'b1, 1'b0, 32'sh8000_0000);
    endtask

    task automatic run_servo_traffic(input int count);
        int                            pick;
        int                            drift;
        logic [1:0]                    code;
        logic signed [TARGET_BITS-1:0] tgt;
        drift = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                drift = $urandom_range(20, 80);
            pick = $urandom_range(0, 99);
            code = 2'($urandom_range(0, 3));
            tgt  = $urandom;
            if (pick < 55)
            begin
                // legal step, biased so the count wanders away from zero
                code = next_fwd(enc_prev_code);
                if ($urandom_range(0, 99) >= drift)
                    code = next_fwd(next_fwd(code));
                send_item(MODE_SAMPLE, code[0], code[1], tgt);
            end
            else if (pick < 63)
                send_item(MODE_SAMPLE, code[0], code[1], tgt);
            else if (pick < 93)
            begin
                tgt = TARGET_BITS'(enc_count) + TARGET_BITS'(int'($urandom_range(0, 520)) - 260);
                send_item(MODE_TICK, code[0], code[1], tgt);
            end
            else if (pick < 96)
                send_item(MODE_TICK, code[0], code[1], TARGET_BITS'(enc_count));
            else
                send_item(MODE_TICK, code[0], code[1], tgt);
        end
    endtask

    task automatic test_scale_setting(input logic [SCALE_BITS-1:0] value, input int count);
        write_scale(value);
        run_servo_traffic(count);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = MODE_SAMPLE;
        chan_a          = 1'b0;
        chan_b          = 1'b0;
        target_position = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        enc_count       = '0;
        enc_prev_code   = '0;
        last_drive_dir  = DIR_NONE;
        drive_dir_q     = DIR_NONE;
        drive_duty_q    = '0;
        duty_scale_q    = SCALE_RESET;
        mismatch_count  = 0;
        send_calm       = 0;
        sink_calm       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_command();
        test_encoder_steps();
        test_control_law();
        test_scale_setting(10'd1000, 250);
        test_scale_setting(10'd0, 200);
        test_scale_setting(10'd1023, 200);
        test_scale_setting(SCALE_BITS'($urandom_range(1, 999)), 200);
        test_scale_setting(10'd1, 175);

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(sink_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        servo_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("result beat with nothing pending, position",
                                current_position, 0);
            else
            begin
                want = expected_beats.pop_front();
                if (current_position !== want.pos)
                    report_mismatch("current_position", current_position, want.pos);
                if (drive_direction !== want.dir)
                    report_mismatch("drive_direction", drive_direction, want.dir);
                if (drive_duty !== want.duty)
                    report_mismatch("drive_duty", drive_duty, want.duty);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/qspc_pkg.sv
hdl/qspc_decoder.sv
hdl/qspc_drive.sv
hdl/quadrature_servo_position_controller.sv
sim/tb_quadrature_servo_position_controller.sv
